### hdl/ycc_pkg.sv
package ycc_pkg;

  // Default widths of the sample and fixed-point fields.
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  // Width of the configuration data word.
  localparam int CFG_BITS = 16;

  // Matrix coefficients carry 24 fraction bits; one extra bit holds the integer part.
  localparam int COEF_BITS = 24;
  localparam int KW        = COEF_BITS + 1;

  // Maximum sample value after reset.
  localparam logic [CFG_BITS-1:0] MAX_RESET = 16'd255;

  // Forward (RGB to Y'PbPr) coefficients.
  localparam logic [KW-1:0] K_YR   = 25'd5016388;   // 0.299
  localparam logic [KW-1:0] K_YG   = 25'd9848226;   // 0.587
  localparam logic [KW-1:0] K_YB   = 25'd1912603;   // 0.114
  localparam logic [KW-1:0] K_BR   = 25'd2830920;   // 0.168736
  localparam logic [KW-1:0] K_BG   = 25'd5557688;   // 0.331264
  localparam logic [KW-1:0] K_HALF = 25'd8388608;   // 0.5
  localparam logic [KW-1:0] K_RG   = 25'd7024419;   // 0.418688
  localparam logic [KW-1:0] K_RB   = 25'd1364189;   // 0.081312

  // Inverse (Y'PbPr to RGB) coefficients.
  localparam logic [KW-1:0] K_RPR  = 25'd23521657;  // 1.402
  localparam logic [KW-1:0] K_GPB  = 25'd5773644;   // 0.344136
  localparam logic [KW-1:0] K_GPR  = 25'd11981214;  // 0.714136
  localparam logic [KW-1:0] K_BPB  = 25'd29729227;  // 1.772

  // Conversion direction of one pixel.
  typedef enum logic {
    MODE_TO_YPBPR = 1'b0,
    MODE_TO_RGB   = 1'b1
  } mode_t;

  // Range class of an inverse-path accumulator.
  typedef enum logic [1:0] {
    CLS_MID,
    CLS_LOW,
    CLS_HIGH
  } sample_class_t;

  // Control bits that travel beside the divider lanes.
  typedef struct packed {
    logic  valid;
    mode_t mode;
    logic  luma_sat;
    logic  pb_sat;
    logic  pb_neg;
    logic  pr_sat;
    logic  pr_neg;
  } fwd_flags_t;

endpackage

### hdl/ycc_matrix.sv
module ycc_matrix #(
  parameter int SAMPLE_BITS = ycc_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = ycc_pkg::FRAC_BITS_DEF,
  localparam int UW = ycc_pkg::KW + SAMPLE_BITS,
  localparam int PW = UW + 1,
  localparam int AW = ycc_pkg::KW + FRAC_BITS + 2
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        valid_i,
  input  ycc_pkg::mode_t              mode_i,
  input  logic [SAMPLE_BITS-1:0]      red_i,
  input  logic [SAMPLE_BITS-1:0]      green_i,
  input  logic [SAMPLE_BITS-1:0]      blue_i,
  input  logic [FRAC_BITS:0]          luma_i,
  input  logic signed [FRAC_BITS:0]   pb_i,
  input  logic signed [FRAC_BITS:0]   pr_i,
  output logic                        valid_o,
  output ycc_pkg::mode_t              mode_o,
  output logic signed [PW-1:0]        ny_o,
  output logic signed [PW-1:0]        nb_o,
  output logic signed [PW-1:0]        nr_o,
  output logic signed [AW-1:0]        acc_red_o,
  output logic signed [AW-1:0]        acc_green_o,
  output logic signed [AW-1:0]        acc_blue_o
);

  logic                  v1_r, v2_r;
  ycc_pkg::mode_t        mode1_r, mode2_r;
  logic [UW-1:0]         p_yr_r, p_yg_r, p_yb_r;
  logic [UW-1:0]         p_br_r, p_bg_r, p_bh_r;
  logic [UW-1:0]         p_rh_r, p_rg_r, p_rb_r;
  logic signed [AW-1:0]  p_rpr_r, p_gpb_r, p_gpr_r, p_bpb_r;
  logic [FRAC_BITS:0]    luma1_r;
  logic signed [AW-1:0]  luma_sh;
  logic signed [PW-1:0]  ny_r, nb_r, nr_r;
  logic signed [AW-1:0]  acc_red_r, acc_green_r, acc_blue_r;

  // Valid bits of the two stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= valid_i;
      v2_r <= v1_r;
    end
  end

  // First stage: one coefficient product per register.
  always_ff @(posedge clk) begin
    if (en) begin
      mode1_r <= mode_i;
      p_yr_r  <= ycc_pkg::K_YR * red_i;
      p_yg_r  <= ycc_pkg::K_YG * green_i;
      p_yb_r  <= ycc_pkg::K_YB * blue_i;
      p_br_r  <= ycc_pkg::K_BR * red_i;
      p_bg_r  <= ycc_pkg::K_BG * green_i;
      p_bh_r  <= ycc_pkg::K_HALF * blue_i;
      p_rh_r  <= ycc_pkg::K_HALF * red_i;
      p_rg_r  <= ycc_pkg::K_RG * green_i;
      p_rb_r  <= ycc_pkg::K_RB * blue_i;
      p_rpr_r <= $signed({1'b0, ycc_pkg::K_RPR}) * pr_i;
      p_gpb_r <= $signed({1'b0, ycc_pkg::K_GPB}) * pb_i;
      p_gpr_r <= $signed({1'b0, ycc_pkg::K_GPR}) * pr_i;
      p_bpb_r <= $signed({1'b0, ycc_pkg::K_BPB}) * pb_i;
      luma1_r <= luma_i;
    end
  end

  // Luma aligned to the coefficient scale.
  assign luma_sh = $signed({2'b00, luma1_r, {ycc_pkg::COEF_BITS{1'b0}}});

  // Second stage: the three row sums of each matrix.
  always_ff @(posedge clk) begin
    if (en) begin
      mode2_r     <= mode1_r;
      ny_r        <= $signed({1'b0, p_yr_r}) + $signed({1'b0, p_yg_r})
                     + $signed({1'b0, p_yb_r});
      nb_r        <= $signed({1'b0, p_bh_r}) - $signed({1'b0, p_br_r})
                     - $signed({1'b0, p_bg_r});
      nr_r        <= $signed({1'b0, p_rh_r}) - $signed({1'b0, p_rg_r})
                     - $signed({1'b0, p_rb_r});
      acc_red_r   <= luma_sh + p_rpr_r;
      acc_green_r <= luma_sh - p_gpb_r - p_gpr_r;
      acc_blue_r  <= luma_sh + p_bpb_r;
    end
  end

  assign valid_o     = v2_r;
  assign mode_o      = mode2_r;
  assign ny_o        = ny_r;
  assign nb_o        = nb_r;
  assign nr_o        = nr_r;
  assign acc_red_o   = acc_red_r;
  assign acc_green_o = acc_green_r;
  assign acc_blue_o  = acc_blue_r;

endmodule

### hdl/ycc_fwd_prep.sv
module ycc_fwd_prep #(
  parameter int SAMPLE_BITS = ycc_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = ycc_pkg::FRAC_BITS_DEF,
  localparam int PW = ycc_pkg::KW + SAMPLE_BITS + 1,
  localparam int Q  = FRAC_BITS + 1,
  localparam int NW = SAMPLE_BITS + Q
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    valid_i,
  input  ycc_pkg::mode_t          mode_i,
  input  logic [SAMPLE_BITS-1:0]  max_val,
  input  logic signed [PW-1:0]    ny_i,
  input  logic signed [PW-1:0]    nb_i,
  input  logic signed [PW-1:0]    nr_i,
  output ycc_pkg::fwd_flags_t     flags_o,
  output logic [NW-1:0]           luma_num_o,
  output logic [NW-1:0]           pb_num_o,
  output logic [NW-1:0]           pr_num_o
);

  localparam int CS = ycc_pkg::COEF_BITS - FRAC_BITS;
  localparam int S  = CS + 1;
  localparam int CB = ycc_pkg::COEF_BITS;

  ycc_pkg::fwd_flags_t flags_nxt, flags_r;
  logic [PW-1:0]       luma_lim, chroma_lim;
  logic [PW-1:0]       pb_mag, pr_mag;
  logic                y_pos;
  logic [NW-1:0]       luma_num_nxt, pb_num_nxt, pr_num_nxt;
  logic [NW-1:0]       luma_num_r, pb_num_r, pr_num_r;

  // Dividend for a rounded quotient: (2*mag + d) / (2*d) with d = max << CS,
  // reduced to a division by max alone.
  function automatic logic [NW-1:0] round_num(input logic [PW-1:0] mag,
                                             input logic [SAMPLE_BITS-1:0] m);
    logic [PW:0] half;
    logic [PW:0] n2;
    logic [PW:0] sh;
    half = {{(PW + 1 - SAMPLE_BITS){1'b0}}, m} << CS;
    n2   = {mag, 1'b0} + half;
    sh   = n2 >> S;
    return sh[NW-1:0];
  endfunction

  // Saturation limits: max for luma and max / 2 for chroma, at coefficient scale.
  assign luma_lim   = {{(PW - SAMPLE_BITS - CB){1'b0}}, max_val, {CB{1'b0}}};
  assign chroma_lim = {{(PW - SAMPLE_BITS - CB + 1){1'b0}}, max_val, {(CB - 1){1'b0}}};

  // Sign, magnitude and saturation of each row sum.
  always_comb begin
    flags_nxt       = '0;
    flags_nxt.valid = valid_i;
    flags_nxt.mode  = mode_i;

    y_pos              = !ny_i[PW-1] && (ny_i != '0);
    flags_nxt.luma_sat = y_pos && ($unsigned(ny_i) >= luma_lim);
    luma_num_nxt       = (y_pos && !flags_nxt.luma_sat) ?
                         round_num($unsigned(ny_i), max_val) : '0;

    flags_nxt.pb_neg = nb_i[PW-1];
    pb_mag           = flags_nxt.pb_neg ? $unsigned(-nb_i) : $unsigned(nb_i);
    flags_nxt.pb_sat = pb_mag >= chroma_lim;
    pb_num_nxt       = flags_nxt.pb_sat ? '0 : round_num(pb_mag, max_val);

    flags_nxt.pr_neg = nr_i[PW-1];
    pr_mag           = flags_nxt.pr_neg ? $unsigned(-nr_i) : $unsigned(nr_i);
    flags_nxt.pr_sat = pr_mag >= chroma_lim;
    pr_num_nxt       = flags_nxt.pr_sat ? '0 : round_num(pr_mag, max_val);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (en) begin
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      luma_num_r <= luma_num_nxt;
      pb_num_r   <= pb_num_nxt;
      pr_num_r   <= pr_num_nxt;
    end
  end

  assign flags_o    = flags_r;
  assign luma_num_o = luma_num_r;
  assign pb_num_o   = pb_num_r;
  assign pr_num_o   = pr_num_r;

endmodule

### hdl/ycc_div_lane.sv
module ycc_div_lane #(
  parameter int SAMPLE_BITS = ycc_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = ycc_pkg::FRAC_BITS_DEF,
  localparam int Q  = FRAC_BITS + 1,
  localparam int NW = SAMPLE_BITS + Q
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [SAMPLE_BITS-1:0]  divisor,
  input  logic [NW-1:0]           num,
  output logic [Q-1:0]            quo
);

  // Partial remainder, dividend bits still to shift in, quotient so far.
  logic [SAMPLE_BITS-1:0] rem_r [Q-1];
  logic [Q-1:0]           low_r [Q-1];
  logic [Q-1:0]           quo_r [Q];

  // Restoring division, one quotient bit per stage. The top part of the
  // dividend is already below the divisor, so Q stages give the full quotient.
  for (genvar k = 0; k < Q; k++) begin : g_stage
    logic [SAMPLE_BITS-1:0] rem_in;
    logic [Q-1:0]           low_in;
    logic [Q-1:0]           quo_in;
    logic [SAMPLE_BITS:0]   trial;
    logic [SAMPLE_BITS:0]   diff;
    logic                   take;
    logic [SAMPLE_BITS-1:0] rem_new;

    if (k == 0) begin : g_first
      assign rem_in = num[NW-1:Q];
      assign low_in = num[Q-1:0];
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign trial   = {rem_in, low_in[Q-1]};
    assign diff    = trial - {1'b0, divisor};
    assign take    = trial >= {1'b0, divisor};
    assign rem_new = take ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k] <= {quo_in[Q-2:0], take};
      end
    end

    // The last stage needs no remainder.
    if (k < Q - 1) begin : g_keep
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_new;
          low_r[k] <= low_in << 1;
        end
      end
    end
  end

  assign quo = quo_r[Q-1];

endmodule

### hdl/ycc_inv_scale.sv
module ycc_inv_scale #(
  parameter int SAMPLE_BITS = ycc_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = ycc_pkg::FRAC_BITS_DEF,
  localparam int AW = ycc_pkg::KW + FRAC_BITS + 2,
  localparam int FC = FRAC_BITS + ycc_pkg::COEF_BITS,
  localparam int HB = FC / 2,
  localparam int HW = FC - HB
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [SAMPLE_BITS-1:0]  max_val,
  input  logic signed [AW-1:0]    acc,
  output logic [SAMPLE_BITS-1:0]  sample
);

  ycc_pkg::sample_class_t  cls_nxt, cls_a_r, cls_b_r;
  logic [HW-1:0]           hi_a_r;
  logic [HB-1:0]           lo_a_r;
  logic [HW+SAMPLE_BITS-1:0] pp_hi_r;
  logic [HB+SAMPLE_BITS-1:0] pp_lo_r;
  logic [FC+SAMPLE_BITS-1:0] prod;
  logic [SAMPLE_BITS-1:0]  sample_nxt, sample_r;

  // Range class: at or below zero, at or above one, or in between.
  always_comb begin
    if (acc[AW-1] || (acc == '0)) begin
      cls_nxt = ycc_pkg::CLS_LOW;
    end else if (acc[AW-2:FC] != '0) begin
      cls_nxt = ycc_pkg::CLS_HIGH;
    end else begin
      cls_nxt = ycc_pkg::CLS_MID;
    end
  end

  // Stage one: class and the fraction split in two halves.
  always_ff @(posedge clk) begin
    if (en) begin
      cls_a_r <= cls_nxt;
      hi_a_r  <= acc[FC-1:HB];
      lo_a_r  <= acc[HB-1:0];
    end
  end

  // Stage two: partial products of the fraction and the maximum.
  always_ff @(posedge clk) begin
    if (en) begin
      cls_b_r <= cls_a_r;
      pp_hi_r <= hi_a_r * max_val;
      pp_lo_r <= lo_a_r * max_val;
    end
  end

  // Stage three: full product, truncated to the integer sample, then clamped.
  assign prod = {pp_hi_r, {HB{1'b0}}} + {{(FC - HB){1'b0}}, pp_lo_r};

  always_comb begin
    case (cls_b_r)
      ycc_pkg::CLS_LOW:  sample_nxt = '0;
      ycc_pkg::CLS_HIGH: sample_nxt = max_val;
      default:           sample_nxt = prod[FC+SAMPLE_BITS-1:FC];
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sample_r <= sample_nxt;
    end
  end

  assign sample = sample_r;

endmodule

### hdl/rgb_ypbpr_color_converter.sv
// RGB to BT.601 Y'PbPr converter and its inverse, one pixel per transfer.
// The input channel carries the mode bit and both sets of fields; mode 0
// reads red, green and blue and returns luma, Pb and Pr, mode 1 reads luma,
// Pb and Pr and returns red, green and blue. Fields of the other direction
// come out as zero. Each accepted pixel gives exactly one result.
// From input transfer to out_valid a pixel passes two matrix stages, one
// saturation stage, FRAC_BITS + 1 divider stages and the output register.
// The divider lanes resolve one quotient bit per stage, which sets that depth.
// Throughput is one pixel per clock unless out_stall holds the pipeline;
// no state is carried between pixels.
// cfg_max_sample_value sets the largest sample value; zero acts as one and
// values above the sample range are capped. Write it only while the pipeline
// is empty. Reset empties the pipeline and sets the maximum to 255.
// While out_valid is high and out_stall is asserted, the whole pipeline
// holds and in_stall is raised in the same cycle; nothing is dropped.
module rgb_ypbpr_color_converter #(
  parameter int SAMPLE_BITS = ycc_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = ycc_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [ycc_pkg::CFG_BITS-1:0]      cfg_max_sample_value,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_mode,
  input  logic [SAMPLE_BITS-1:0]            in_red_in,
  input  logic [SAMPLE_BITS-1:0]            in_green_in,
  input  logic [SAMPLE_BITS-1:0]            in_blue_in,
  input  logic [FRAC_BITS:0]                in_luma_in,
  input  logic signed [FRAC_BITS:0]         in_pb_in,
  input  logic signed [FRAC_BITS:0]         in_pr_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [FRAC_BITS:0]                out_luma_out,
  output logic signed [FRAC_BITS:0]         out_pb_out,
  output logic signed [FRAC_BITS:0]         out_pr_out,
  output logic [SAMPLE_BITS-1:0]            out_red_out,
  output logic [SAMPLE_BITS-1:0]            out_green_out,
  output logic [SAMPLE_BITS-1:0]            out_blue_out
);

  localparam int CB  = ycc_pkg::CFG_BITS;
  localparam int Q   = FRAC_BITS + 1;
  localparam int NW  = SAMPLE_BITS + Q;
  localparam int PW  = ycc_pkg::KW + SAMPLE_BITS + 1;
  localparam int AW  = ycc_pkg::KW + FRAC_BITS + 2;
  localparam int DLY = Q - 2;

  localparam logic [CB-1:0]       MAX_CAP     = CB'((1 << SAMPLE_BITS) - 1);
  localparam logic [FRAC_BITS:0]  LUMA_ONE    = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [FRAC_BITS:0]  CHROMA_HALF = {2'b01, {(FRAC_BITS - 1){1'b0}}};

  logic                     adv;
  logic [SAMPLE_BITS-1:0]   max_nxt, max_r;

  logic                     m_valid;
  ycc_pkg::mode_t           m_mode;
  logic signed [PW-1:0]     ny, nb, nr;
  logic signed [AW-1:0]     acc_red, acc_green, acc_blue;

  ycc_pkg::fwd_flags_t      flags_p;
  logic [NW-1:0]            luma_num, pb_num, pr_num;
  logic [Q-1:0]             q_luma, q_pb, q_pr;
  logic [SAMPLE_BITS-1:0]   red_s, green_s, blue_s;

  ycc_pkg::fwd_flags_t      flags_dly_r [Q];
  logic [SAMPLE_BITS-1:0]   red_dly_r   [DLY];
  logic [SAMPLE_BITS-1:0]   green_dly_r [DLY];
  logic [SAMPLE_BITS-1:0]   blue_dly_r  [DLY];
  ycc_pkg::fwd_flags_t      flags_last;

  logic [FRAC_BITS:0]       pb_res, pr_res;
  logic [FRAC_BITS:0]       luma_nxt, pb_nxt, pr_nxt;
  logic [SAMPLE_BITS-1:0]   red_nxt, green_nxt, blue_nxt;

  logic                     out_valid_r;
  logic [FRAC_BITS:0]       luma_out_r, pb_out_r, pr_out_r;
  logic [SAMPLE_BITS-1:0]   red_out_r, green_out_r, blue_out_r;

  // The pipeline moves whenever the output register is free or being taken.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // Effective maximum: zero acts as one, values beyond the sample range cap.
  always_comb begin
    if (cfg_max_sample_value == '0) begin
      max_nxt = SAMPLE_BITS'(1);
    end else if (cfg_max_sample_value > MAX_CAP) begin
      max_nxt = '1;
    end else begin
      max_nxt = cfg_max_sample_value[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_r <= SAMPLE_BITS'(ycc_pkg::MAX_RESET);
    end else if (cfg_wr_en) begin
      max_r <= max_nxt;
    end
  end

  // Matrix products and row sums for both directions.
  ycc_matrix #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_matrix (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (adv),
    .valid_i     (in_valid),
    .mode_i      (ycc_pkg::mode_t'(in_mode)),
    .red_i       (in_red_in),
    .green_i     (in_green_in),
    .blue_i      (in_blue_in),
    .luma_i      (in_luma_in),
    .pb_i        (in_pb_in),
    .pr_i        (in_pr_in),
    .valid_o     (m_valid),
    .mode_o      (m_mode),
    .ny_o        (ny),
    .nb_o        (nb),
    .nr_o        (nr),
    .acc_red_o   (acc_red),
    .acc_green_o (acc_green),
    .acc_blue_o  (acc_blue)
  );

  // Forward path: saturation and dividends.
  ycc_fwd_prep #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_fwd_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .valid_i    (m_valid),
    .mode_i     (m_mode),
    .max_val    (max_r),
    .ny_i       (ny),
    .nb_i       (nb),
    .nr_i       (nr),
    .flags_o    (flags_p),
    .luma_num_o (luma_num),
    .pb_num_o   (pb_num),
    .pr_num_o   (pr_num)
  );

  // Forward path: division by the maximum, one lane per component.
  ycc_div_lane #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_div_luma (
    .clk (clk), .en (adv), .divisor (max_r), .num (luma_num), .quo (q_luma)
  );

  ycc_div_lane #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_div_pb (
    .clk (clk), .en (adv), .divisor (max_r), .num (pb_num), .quo (q_pb)
  );

  ycc_div_lane #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_div_pr (
    .clk (clk), .en (adv), .divisor (max_r), .num (pr_num), .quo (q_pr)
  );

  // Inverse path: clamp and scale each channel by the maximum.
  ycc_inv_scale #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_inv_red (
    .clk (clk), .en (adv), .max_val (max_r), .acc (acc_red), .sample (red_s)
  );

  ycc_inv_scale #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_inv_green (
    .clk (clk), .en (adv), .max_val (max_r), .acc (acc_green), .sample (green_s)
  );

  ycc_inv_scale #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_inv_blue (
    .clk (clk), .en (adv), .max_val (max_r), .acc (acc_blue), .sample (blue_s)
  );

  // Valid, mode and saturation flags ride alongside the divider stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < Q; i++) begin
        flags_dly_r[i] <= '0;
      end
    end else if (adv) begin
      flags_dly_r[0] <= flags_p;
      for (int i = 1; i < Q; i++) begin
        flags_dly_r[i] <= flags_dly_r[i-1];
      end
    end
  end

  // Inverse results wait until the divider lanes catch up.
  always_ff @(posedge clk) begin
    if (adv) begin
      red_dly_r[0]   <= red_s;
      green_dly_r[0] <= green_s;
      blue_dly_r[0]  <= blue_s;
      for (int i = 1; i < DLY; i++) begin
        red_dly_r[i]   <= red_dly_r[i-1];
        green_dly_r[i] <= green_dly_r[i-1];
        blue_dly_r[i]  <= blue_dly_r[i-1];
      end
    end
  end

  assign flags_last = flags_dly_r[Q-1];

  // Final selection: saturated or divided values, signs, and mode masking.
  always_comb begin
    pb_res = flags_last.pb_sat ? CHROMA_HALF : q_pb;
    pr_res = flags_last.pr_sat ? CHROMA_HALF : q_pr;
    if (flags_last.mode == ycc_pkg::MODE_TO_RGB) begin
      luma_nxt  = '0;
      pb_nxt    = '0;
      pr_nxt    = '0;
      red_nxt   = red_dly_r[DLY-1];
      green_nxt = green_dly_r[DLY-1];
      blue_nxt  = blue_dly_r[DLY-1];
    end else begin
      luma_nxt  = flags_last.luma_sat ? LUMA_ONE : q_luma;
      pb_nxt    = flags_last.pb_neg ? -pb_res : pb_res;
      pr_nxt    = flags_last.pr_neg ? -pr_res : pr_res;
      red_nxt   = '0;
      green_nxt = '0;
      blue_nxt  = '0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= flags_last.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      luma_out_r  <= luma_nxt;
      pb_out_r    <= pb_nxt;
      pr_out_r    <= pr_nxt;
      red_out_r   <= red_nxt;
      green_out_r <= green_nxt;
      blue_out_r  <= blue_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_luma_out  = luma_out_r;
  assign out_pb_out    = $signed(pb_out_r);
  assign out_pr_out    = $signed(pr_out_r);
  assign out_red_out   = red_out_r;
  assign out_green_out = green_out_r;
  assign out_blue_out  = blue_out_r;

endmodule

### hdl/ycc_checker.sv
module ycc_checker #(
  parameter int SAMPLE_BITS = ycc_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = ycc_pkg::FRAC_BITS_DEF
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [FRAC_BITS:0]          out_luma_out,
  input logic signed [FRAC_BITS:0]   out_pb_out,
  input logic signed [FRAC_BITS:0]   out_pr_out,
  input logic [SAMPLE_BITS-1:0]      out_red_out,
  input logic [SAMPLE_BITS-1:0]      out_green_out,
  input logic [SAMPLE_BITS-1:0]      out_blue_out
);

  localparam int LUMA_ONE   = 1 << FRAC_BITS;
  localparam int CHROMA_LIM = 1 << (FRAC_BITS - 1);

  // The input side is held back exactly when a result is waiting on a stall.
  a_stall_backpressure: assert property (
    @(posedge clk) in_stall == (out_valid && out_stall)
  ) else $error("in_stall does not follow the output stall");

  // Only one direction's fields may be nonzero in a result.
  a_mode_exclusive: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_red_out == '0 && out_green_out == '0 && out_blue_out == '0) ||
                   (out_luma_out == '0 && out_pb_out == '0 && out_pr_out == '0))
  ) else $error("result carries fields of both directions");

  // Luma stays in [0,1] and chroma in [-1/2,1/2].
  a_ycc_range: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_luma_out <= LUMA_ONE &&
                   out_pb_out <= CHROMA_LIM && out_pb_out >= -CHROMA_LIM &&
                   out_pr_out <= CHROMA_LIM && out_pr_out >= -CHROMA_LIM)
  ) else $error("luma or chroma result out of range");

  // A stalled result stays on the port unchanged.
  a_stall_hold: assert property (
    @(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_luma_out) &&
      $stable(out_pb_out) && $stable(out_pr_out) && $stable(out_red_out) &&
      $stable(out_green_out) && $stable(out_blue_out))
  ) else $error("stalled result changed or was dropped");

endmodule

bind rgb_ypbpr_color_converter ycc_checker #(
  .SAMPLE_BITS (SAMPLE_BITS),
  .FRAC_BITS   (FRAC_BITS)
) u_ycc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_stall      (in_stall),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_luma_out  (out_luma_out),
  .out_pb_out    (out_pb_out),
  .out_pr_out    (out_pr_out),
  .out_red_out   (out_red_out),
  .out_green_out (out_green_out),
  .out_blue_out  (out_blue_out)
);
